// File: sv/start_byte_length_deframer_macros.svh
// Assertion macros for the start-byte length deframer.
`ifndef START_BYTE_LENGTH_DEFRAMER_MACROS_SVH
`define START_BYTE_LENGTH_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBLD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbld assertion failed");

// Next-cycle implication, disabled during reset.
`define SBLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbld assertion failed");

`endif

// File: sv/sbld_pkg.sv
// Types and constants shared by the start-byte length deframer.
`timescale 1ns / 1ps
`default_nettype none
package sbld_pkg;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned LenW      = 16;
   localparam int unsigned CsrIndexW = 2;
   localparam int unsigned CsrDataW  = 16;

   localparam logic [ByteW-1:0] StartMarkerReset = 8'h7E;
   localparam logic [LenW-1:0]  MaxLengthReset   = 16'd4096;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_MAX_LENGTH   = 2'd1
   } csr_index_type;

   // outcome of a check on a full four-byte header window
   typedef struct packed {
      logic             accept;
      logic             empty;
      logic [ByteW-1:0] chan;
      logic [LenW-1:0]  len;
   } hdr_verdict_type;

   typedef struct packed {
      logic [ByteW-1:0] chan;
      logic [ByteW-1:0] data_byte;
      logic             last_byte;
      logic             empty_packet;
   } result_type;

endpackage
`default_nettype wire

// File: sv/sbld_hdr_check.sv
// Header check: start marker, non-zero channel and length limit.
`timescale 1ns / 1ps
`default_nettype none
module sbld_hdr_check
   import sbld_pkg::*;
(
   input  wire logic [ByteW-1:0] hdr_start,
   input  wire logic [ByteW-1:0] hdr_chan,
   input  wire logic [ByteW-1:0] hdr_len_hi,
   input  wire logic [ByteW-1:0] hdr_len_lo,
   input  wire logic [ByteW-1:0] start_marker,
   input  wire logic [LenW-1:0]  max_length,
   output hdr_verdict_type       verdict
);

   logic [LenW-1:0] len;

   always_comb begin
      len            = {hdr_len_hi, hdr_len_lo};
      verdict.chan   = hdr_chan;
      verdict.len    = len;
      verdict.accept = (hdr_start == start_marker) && (hdr_chan != '0) &&
                       (len <= max_length);
      verdict.empty  = (len == '0);
   end

endmodule
`default_nettype wire

// File: sv/start_byte_length_deframer.sv
// Start-byte length deframer: one received byte per transaction.
// Throughput: one byte per cycle while req_ready is high; a two-entry output stage (register
// plus skid) holds one result while the result side stalls, and req_ready drops while the skid is full.
// Reset (synchronous, active high): hunting for a header, empty window, registers back
// to start marker 0x7E and length limit 4096, output stage empty.
`timescale 1ns / 1ps
`default_nettype none
`include "start_byte_length_deframer_macros.svh"
module start_byte_length_deframer
   import sbld_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [ByteW-1:0]     req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ByteW-1:0]          rsp_chan,
   output logic [ByteW-1:0]          rsp_data_byte,
   output logic                      rsp_last_byte,
   output logic                      rsp_empty_packet,
   input  wire logic                 csr_write_en,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_wdata
);

   logic [ByteW-1:0] start_marker_ff, start_marker_in;
   logic [LenW-1:0]  max_length_ff, max_length_in;

   logic [ByteW-1:0] win0_ff, win0_in;
   logic [ByteW-1:0] win1_ff, win1_in;
   logic [ByteW-1:0] win2_ff, win2_in;
   logic [1:0]       fill_ff, fill_in;
   logic             in_payload_ff, in_payload_in;
   logic [LenW-1:0]  bytes_left_ff, bytes_left_in;
   logic [ByteW-1:0] frame_chan_ff, frame_chan_in;

   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic             skid_valid_ff, skid_valid_in;
   result_type       skid_ff, skid_in;

   logic             accept;
   logic             res_valid;
   result_type       res;
   hdr_verdict_type  verdict;
   logic             pay_last;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pay_last  = (bytes_left_ff <= LenW'(1));

   sbld_hdr_check u_hdr_check (
      .hdr_start    (win0_ff),
      .hdr_chan     (win1_ff),
      .hdr_len_hi   (win2_ff),
      .hdr_len_lo   (req_rx_byte),
      .start_marker (start_marker_ff),
      .max_length   (max_length_ff),
      .verdict      (verdict)
   );

   // configuration registers
   always_comb begin
      start_marker_in = start_marker_ff;
      max_length_in   = max_length_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_wdata[ByteW-1:0];
            CSR_MAX_LENGTH:   max_length_in   = csr_wdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   // framing state and the result of this transaction
   always_comb begin
      win0_in          = win0_ff;
      win1_in          = win1_ff;
      win2_in          = win2_ff;
      fill_in          = fill_ff;
      in_payload_in    = in_payload_ff;
      bytes_left_in    = bytes_left_ff;
      frame_chan_in    = frame_chan_ff;
      res_valid        = 1'b0;
      res.chan         = frame_chan_ff;
      res.data_byte    = req_rx_byte;
      res.last_byte    = 1'b0;
      res.empty_packet = 1'b0;
      if (accept) begin
         priority if (in_payload_ff) begin
            res_valid     = 1'b1;
            res.last_byte = pay_last;
            if (pay_last) begin
               in_payload_in = 1'b0;
               bytes_left_in = '0;
            end else begin
               bytes_left_in = bytes_left_ff - LenW'(1);
            end
         end else if (fill_ff != 2'd3) begin
            unique case (fill_ff)
               2'd0:    win0_in = req_rx_byte;
               2'd1:    win1_in = req_rx_byte;
               default: win2_in = req_rx_byte;
            endcase
            fill_in = fill_ff + 2'd1;
         end else if (!verdict.accept) begin
            // drop only the first byte and rescan the rest
            win0_in = win1_ff;
            win1_in = win2_ff;
            win2_in = req_rx_byte;
         end else begin
            win0_in       = '0;
            win1_in       = '0;
            win2_in       = '0;
            fill_in       = 2'd0;
            frame_chan_in = verdict.chan;
            if (verdict.empty) begin
               res_valid        = 1'b1;
               res.chan         = verdict.chan;
               res.data_byte    = '0;
               res.last_byte    = 1'b1;
               res.empty_packet = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               bytes_left_in = verdict.len;
            end
         end
      end
   end

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ready) begin
         out_valid_in  = skid_valid_ff || res_valid;
         out_in        = skid_valid_ff ? skid_ff : res;
         skid_valid_in = 1'b0;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= StartMarkerReset;
         max_length_ff   <= MaxLengthReset;
         win0_ff         <= '0;
         win1_ff         <= '0;
         win2_ff         <= '0;
         fill_ff         <= 2'd0;
         in_payload_ff   <= 1'b0;
         bytes_left_ff   <= '0;
         frame_chan_ff   <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         start_marker_ff <= start_marker_in;
         max_length_ff   <= max_length_in;
         win0_ff         <= win0_in;
         win1_ff         <= win1_in;
         win2_ff         <= win2_in;
         fill_ff         <= fill_in;
         in_payload_ff   <= in_payload_in;
         bytes_left_ff   <= bytes_left_in;
         frame_chan_ff   <= frame_chan_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_chan         = out_ff.chan;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_last_byte    = out_ff.last_byte;
   assign rsp_empty_packet = out_ff.empty_packet;

   `SBLD_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `SBLD_ASSERT_SAME(a_payload_window_empty, clock, reset, in_payload_ff, fill_ff == 2'd0)
   `SBLD_ASSERT_SAME(a_empty_is_last, clock, reset, out_valid_ff && out_ff.empty_packet,
                     out_ff.last_byte && (out_ff.data_byte == '0))
   `SBLD_ASSERT_NEXT(a_payload_continues, clock, reset,
                     in_payload_ff && accept && (bytes_left_ff > LenW'(1)), in_payload_ff)

endmodule
`default_nettype wire

// File: bench/start_byte_length_deframer_test.sv
// Self-checking testbench for the start-byte length deframer: directed table, then random phases.
`timescale 1ns / 1ps
module start_byte_length_deframer_test;
   import sbld_pkg::*;

   localparam int unsigned CycleLimit = 500000;
   localparam int unsigned PhaseBytes = 330;
   localparam int unsigned PhaseCount = 6;
   localparam logic [CsrIndexW-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum {ROW_MODEL, ROW_QUIET, ROW_RESULT} row_kind_type;

   typedef struct {
      logic [ByteW-1:0] rx;
      row_kind_type     kind;
      result_type       want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [ByteW-1:0]     req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ByteW-1:0]     rsp_chan;
   logic [ByteW-1:0]     rsp_data_byte;
   logic                 rsp_last_byte;
   logic                 rsp_empty_packet;
   logic                 csr_write_en;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;

   // deframer state as the testbench sees it
   logic [ByteW-1:0] start_marker_cfg = StartMarkerReset;
   logic [LenW-1:0]  max_length_cfg   = MaxLengthReset;
   logic [ByteW-1:0] hdr_window [4]   = '{default: '0};
   logic [2:0]       window_fill      = '0;
   bit               in_frame         = 1'b0;
   logic [LenW-1:0]  payload_left     = '0;
   logic [ByteW-1:0] frame_chan       = '0;

   result_type  expected_results [$];
   int unsigned cycle_count     = 0;
   int unsigned bytes_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned frame_ends      = 0;
   int unsigned empty_packets   = 0;
   int unsigned mismatch_count  = 0;
   int unsigned send_idle_pct   = 20;
   int unsigned recv_idle_pct   = 80;
   int unsigned hold_cycles     = 0;

   stim_row_type directed_rows [24] = '{
      '{8'h00, ROW_QUIET,  '0},
      '{8'h7E, ROW_QUIET,  '0},
      '{8'h05, ROW_QUIET,  '0},
      '{8'h00, ROW_QUIET,  '0},
      '{8'h00, ROW_RESULT, {8'h05, 8'h00, 1'b1, 1'b1}},
      '{8'h7E, ROW_QUIET,  '0},
      '{8'hFF, ROW_QUIET,  '0},
      '{8'h00, ROW_QUIET,  '0},
      '{8'h02, ROW_QUIET,  '0},
      '{8'h00, ROW_RESULT, {8'hFF, 8'h00, 1'b0, 1'b0}},
      '{8'hFF, ROW_RESULT, {8'hFF, 8'hFF, 1'b1, 1'b0}},
      '{8'h7E, ROW_MODEL,  '0},
      '{8'h01, ROW_MODEL,  '0},
      '{8'h10, ROW_MODEL,  '0},
      '{8'h01, ROW_MODEL,  '0},
      '{8'h7E, ROW_MODEL,  '0},
      '{8'h02, ROW_MODEL,  '0},
      '{8'h00, ROW_MODEL,  '0},
      '{8'h01, ROW_MODEL,  '0},
      '{8'h5A, ROW_MODEL,  '0},
      '{8'h7E, ROW_QUIET,  '0},
      '{8'h00, ROW_QUIET,  '0},
      '{8'h10, ROW_QUIET,  '0},
      '{8'h00, ROW_QUIET,  '0}
   };

   start_byte_length_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chan         (rsp_chan),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_empty_packet (rsp_empty_packet),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one received byte through the deframer; returns 1 when it yields a result
   function automatic bit deframe_byte(input logic [ByteW-1:0] rx, output result_type res);
      logic [LenW-1:0] hdr_len;
      res = '0;
      if (in_frame) begin
         res = {frame_chan, rx, payload_left <= LenW'(1), 1'b0};
         if (payload_left <= LenW'(1)) begin
            payload_left = '0;
            in_frame = 1'b0;
         end else begin
            payload_left = payload_left - 1'b1;
         end
         return 1'b1;
      end
      if (window_fill >= 4) window_fill = 3'd3;
      hdr_window[window_fill[1:0]] = rx;
      window_fill = window_fill + 1'b1;
      if (window_fill < 4) return 1'b0;
      hdr_len = {hdr_window[2], hdr_window[3]};
      if (hdr_window[0] != start_marker_cfg || hdr_window[1] == '0
          || hdr_len > max_length_cfg) begin
         hdr_window[0] = hdr_window[1];
         hdr_window[1] = hdr_window[2];
         hdr_window[2] = hdr_window[3];
         hdr_window[3] = '0;
         window_fill = 3'd3;
         return 1'b0;
      end
      frame_chan = hdr_window[1];
      hdr_window = '{default: '0};
      window_fill = '0;
      if (hdr_len == '0) begin
         res = {frame_chan, 8'h00, 1'b1, 1'b1};
         return 1'b1;
      end
      in_frame = 1'b1;
      payload_left = hdr_len;
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input result_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected chan %h data %h last %b empty %b, got %h %h %b %b",
                  $realtime, what, want.chan, want.data_byte, want.last_byte,
                  want.empty_packet, rsp_chan, rsp_data_byte, rsp_last_byte,
                  rsp_empty_packet);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (rsp_last_byte) frame_ends++;
         if (rsp_empty_packet) empty_packets++;
         if (expected_results.size() == 0) begin
            note_mismatch("unexpected transaction", '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan != want.chan || rsp_data_byte != want.data_byte
                || rsp_last_byte != want.last_byte
                || rsp_empty_packet != want.empty_packet)
               note_mismatch("result mismatch", want);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] rx, input row_kind_type kind = ROW_MODEL,
                            input result_type want = '0);
      result_type res;
      bit         has_res;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      has_res = deframe_byte(rx, res);
      bytes_sent++;
      if (kind == ROW_RESULT)
         expected_results.push_back(want);
      else if (kind == ROW_MODEL && has_res)
         expected_results.push_back(res);
   endtask

   task automatic send_header(input logic [ByteW-1:0] marker, input logic [ByteW-1:0] chan,
                              input logic [LenW-1:0] len);
      send_byte(marker);
      send_byte(chan);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   // sender stops and waits for every outstanding transaction to come out
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_START_MARKER)
         start_marker_cfg = val[ByteW-1:0];
      else if (idx == CSR_MAX_LENGTH)
         max_length_cfg = val;
   endtask

   task automatic send_random_sequence();
      int unsigned      pick;
      int unsigned      len;
      logic [ByteW-1:0] chan;
      pick = $urandom_range(0, 99);
      chan = 8'($urandom_range(1, 255));
      if (pick < 60) begin
         len = $urandom_range(0, (max_length_cfg < 8) ? int'(max_length_cfg) : 8);
         if (max_length_cfg <= 64 && $urandom_range(0, 9) == 0) len = int'(max_length_cfg);
         send_header(start_marker_cfg, chan, 16'(len));
         repeat (len) send_byte(8'($urandom));
      end else if (pick < 70) begin
         send_header(start_marker_cfg, 8'h00, 16'($urandom));
      end else if (pick < 80 && max_length_cfg != 16'hFFFF) begin
         len = int'(max_length_cfg) + 1 + $urandom_range(0, 3);
         if (len > 65535) len = 65535;
         send_header(start_marker_cfg, chan, 16'(len));
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
         send_byte(start_marker_cfg);
         if ($urandom_range(0, 1) == 1) send_byte(chan);
      end
   endtask

   initial begin
      logic [ByteW-1:0] phase_marker [PhaseCount];
      logic [LenW-1:0]  phase_max    [PhaseCount];
      int unsigned      phase_start;
      bit               paused;
      phase_marker = '{8'h7E, 8'h00, 8'hFF, 8'h7E, 8'($urandom), 8'($urandom)};
      phase_max    = '{16'd4096, 16'd0, 16'hFFFF, 16'd5, 16'd3, 16'd12};
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_START_MARKER;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].want);

      for (int p = 0; p < PhaseCount; p++) begin
         drain_results();
         if (p == 0) begin
            write_register(CSR_SPARE_2, 16'hFFFF);
            write_register(CSR_SPARE_3, 16'h0000);
         end
         write_register(CSR_START_MARKER, {8'($urandom), phase_marker[p]});
         write_register(CSR_MAX_LENGTH, phase_max[p]);
         @(negedge clock);
         csr_write_en <= 1'b0;
         send_idle_pct = (p < 2) ? 20 : (p < 4) ? 80 : 0;
         recv_idle_pct = (p < 2) ? 80 : (p < 4) ? 20 : 0;
         if (p == 0) hold_cycles = 400;
         phase_start = bytes_sent;
         paused = 1'b0;
         while (bytes_sent - phase_start < PhaseBytes) begin
            if (!paused && bytes_sent - phase_start >= PhaseBytes / 2) begin
               drain_results();
               paused = 1'b1;
            end
            send_random_sequence();
         end
         // leave a frame open, where the length limit admits it, so the next register write lands mid-payload
         send_header(start_marker_cfg, 8'h07, 16'd3);
         send_byte(8'($urandom));
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("%0d bytes offered over %0d register settings with skewed and no idling,",
               bytes_sent, PhaseCount + 1);
      $display("%0d results compared: %0d frame ends, %0d empty packets, %0d mismatches",
               results_checked, frame_ends, empty_packets, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: start_byte_length_deframer.f
+incdir+sv
sv/sbld_pkg.sv
sv/sbld_hdr_check.sv
sv/start_byte_length_deframer.sv
bench/start_byte_length_deframer_test.sv
